[design/pid_velocity_controller_defines.svh]
// Assertion macros for the PID velocity controller.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef PID_VELOCITY_CONTROLLER_DEFINES_SVH
`define PID_VELOCITY_CONTROLLER_DEFINES_SVH

// Consequent must hold at the same edge as the antecedent.
`define PVC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define PVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pvc_pkg.sv]
// Shared constants for the PID velocity controller: field widths,
// configuration register indexes and input command codes. No dependencies.
`timescale 1ns / 1ps

package pvc_pkg;

  // Field widths.
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 31;
  localparam int FF_GAIN_W = 17;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_LIM   = 3'd5;

  // Input command codes.
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

endpackage

[design/pid_velocity_controller.sv]
// Single-joint PID position loop producing a velocity command (Q16.16).
// Depends on pvc_pkg and pid_velocity_controller_defines.svh.
`timescale 1ns / 1ps
`include "pid_velocity_controller_defines.svh"

// The controller accepts one item per clock while the result side is ready and
// returns one result per item, in order. Three register stages set the timing: an
// item passes from the stage-one register to the stage-two register to the result
// register, where it is presented until it transfers. The input stalls only when
// all three stages hold an item and the result side is not ready.
// Stage one registers the input item, stage two registers the four gain
// products (position error, velocity error and feedforward terms), and stage
// three updates the integral and previous command and registers the result; the
// feedback through the integral and previous command closes inside that last
// stage, so back-to-back items see each other's state. A clear item (cmd = 1)
// returns zero and zeroes the integral and previous command. The user must write
// gains and limits through the cfg_ port only while no item is in flight; the
// block does not enforce this, and all of them reset to zero.
module pid_velocity_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [pvc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pvc_pkg::GAIN_W-1:0]          cfg_wdata,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [pvc_pkg::DATA_W-1:0]   in_target_position,
  input  logic signed [pvc_pkg::DATA_W-1:0]   in_feedforward_velocity,
  input  logic signed [pvc_pkg::DATA_W-1:0]   in_measured_position,
  input  logic signed [pvc_pkg::DATA_W-1:0]   in_measured_velocity,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pvc_pkg::DATA_W-1:0]   out_velocity_command
);

  // Configuration registers.
  logic [pvc_pkg::GAIN_W-1:0]    kp_r, kp_nxt;
  logic [pvc_pkg::GAIN_W-1:0]    ki_r, ki_nxt;
  logic [pvc_pkg::GAIN_W-1:0]    kd_r, kd_nxt;
  logic [pvc_pkg::FF_GAIN_W-1:0] kff_r, kff_nxt;
  logic [pvc_pkg::GAIN_W-1:0]    ilim_r, ilim_nxt;
  logic [pvc_pkg::GAIN_W-1:0]    vlim_r, vlim_nxt;

  // Stage one: input register.
  logic                v1_r, v1_nxt;
  logic                cmd1_r;
  logic signed [31:0]  tp1_r, ff1_r, mp1_r, mv1_r;

  // Stage two: floored gain products.
  logic                v2_r, v2_nxt;
  logic                clr2_r;
  logic signed [47:0]  p2_r, i2_r, d2_r;
  logic signed [33:0]  f2_r;

  // Stage three: result register and loop state.
  logic                out_valid_r, out_valid_nxt;
  logic signed [31:0]  velocity_command_r, velocity_command_nxt;
  logic signed [31:0]  integ_r, integ_nxt;
  logic signed [31:0]  last_r, last_nxt;

  // Handshake between stages.
  logic rdy2, rdy3, fire2, fire3;

  // Stage one datapath.
  logic signed [32:0]  perr, verr;
  logic signed [63:0]  perr_ext, verr_ext, kp_ext, ki_ext, kd_ext;
  logic signed [63:0]  prod_p, prod_i, prod_d;
  logic signed [49:0]  ff_ext, kff_ext, prod_f;

  // Stage two datapath.
  logic signed [32:0]  last_ext, last_mag;
  logic                windup_ok;
  logic signed [48:0]  integ_acc, ilim_pos, ilim_neg;
  logic signed [31:0]  integ_clamp;
  logic signed [49:0]  sum, vlim_pos, vlim_neg;
  logic signed [31:0]  cmd_clamp;

  // Configuration writes; indexes past the list are ignored.
  always_comb begin
    kp_nxt   = kp_r;
    ki_nxt   = ki_r;
    kd_nxt   = kd_r;
    kff_nxt  = kff_r;
    ilim_nxt = ilim_r;
    vlim_nxt = vlim_r;
    if (cfg_we) begin
      case (cfg_index)
        pvc_pkg::REG_GAIN_P:    kp_nxt   = cfg_wdata;
        pvc_pkg::REG_GAIN_I:    ki_nxt   = cfg_wdata;
        pvc_pkg::REG_GAIN_D:    kd_nxt   = cfg_wdata;
        pvc_pkg::REG_GAIN_FF:   kff_nxt  = cfg_wdata[pvc_pkg::FF_GAIN_W-1:0];
        pvc_pkg::REG_INTEG_LIM: ilim_nxt = cfg_wdata;
        pvc_pkg::REG_VEL_LIM:   vlim_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      kff_r  <= '0;
      ilim_r <= '0;
      vlim_r <= '0;
    end else begin
      kp_r   <= kp_nxt;
      ki_r   <= ki_nxt;
      kd_r   <= kd_nxt;
      kff_r  <= kff_nxt;
      ilim_r <= ilim_nxt;
      vlim_r <= vlim_nxt;
    end
  end

  // Each stage takes a new item when it is empty or its content moves on.
  assign rdy3     = !out_valid_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;
  assign fire2    = v1_r && rdy2;
  assign fire3    = v2_r && rdy3;

  assign v1_nxt        = in_ready ? in_valid : v1_r;
  assign v2_nxt        = rdy2 ? v1_r : v2_r;
  assign out_valid_nxt = rdy3 ? v2_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register loads on each input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd1_r <= in_cmd;
      tp1_r  <= in_target_position;
      ff1_r  <= in_feedforward_velocity;
      mp1_r  <= in_measured_position;
      mv1_r  <= in_measured_velocity;
    end
  end

  // Errors are exact at 33 bits; products are exact and the upper slice is the
  // Q16.16 result floored toward minus infinity.
  always_comb begin
    perr     = $signed({tp1_r[31], tp1_r}) - $signed({mp1_r[31], mp1_r});
    verr     = $signed({ff1_r[31], ff1_r}) - $signed({mv1_r[31], mv1_r});
    perr_ext = $signed({{31{perr[32]}}, perr});
    verr_ext = $signed({{31{verr[32]}}, verr});
    kp_ext   = $signed({33'd0, kp_r});
    ki_ext   = $signed({33'd0, ki_r});
    kd_ext   = $signed({33'd0, kd_r});
    ff_ext   = $signed({{18{ff1_r[31]}}, ff1_r});
    kff_ext  = $signed({33'd0, kff_r});
    prod_p   = kp_ext * perr_ext;
    prod_i   = ki_ext * perr_ext;
    prod_d   = kd_ext * verr_ext;
    prod_f   = kff_ext * ff_ext;
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      clr2_r <= (cmd1_r == pvc_pkg::CMD_CLEAR);
      p2_r   <= prod_p[63:16];
      i2_r   <= prod_i[63:16];
      d2_r   <= prod_d[63:16];
      f2_r   <= prod_f[49:16];
    end
  end

  // Integral update: accumulate only while the previous command is inside the
  // velocity limit, then always clamp to the integral limit.
  always_comb begin
    last_ext  = $signed({last_r[31], last_r});
    last_mag  = last_r[31] ? -last_ext : last_ext;
    windup_ok = $unsigned(last_mag) < {2'b00, vlim_r};
    integ_acc = $signed({{17{integ_r[31]}}, integ_r})
              + (windup_ok ? $signed({i2_r[47], i2_r}) : 49'sd0);
    ilim_pos  = $signed({18'd0, ilim_r});
    ilim_neg  = -ilim_pos;
    if (integ_acc > ilim_pos) begin
      integ_clamp = ilim_pos[31:0];
    end else if (integ_acc < ilim_neg) begin
      integ_clamp = ilim_neg[31:0];
    end else begin
      integ_clamp = integ_acc[31:0];
    end
  end

  // Command sum and clamp. The velocity limit never exceeds the signed 32-bit
  // range, so clamping the exact sum also covers the 32-bit saturation.
  always_comb begin
    sum = $signed({{2{p2_r[47]}}, p2_r})
        + $signed({{18{integ_clamp[31]}}, integ_clamp})
        + $signed({{2{d2_r[47]}}, d2_r})
        + $signed({{16{f2_r[33]}}, f2_r});
    vlim_pos = $signed({19'd0, vlim_r});
    vlim_neg = -vlim_pos;
    if (sum > vlim_pos) begin
      cmd_clamp = vlim_pos[31:0];
    end else if (sum < vlim_neg) begin
      cmd_clamp = vlim_neg[31:0];
    end else begin
      cmd_clamp = sum[31:0];
    end
  end

  // Loop state and result advance together when stage two moves on.
  always_comb begin
    integ_nxt            = integ_r;
    last_nxt             = last_r;
    velocity_command_nxt = velocity_command_r;
    if (fire3) begin
      if (clr2_r) begin
        integ_nxt            = '0;
        last_nxt             = '0;
        velocity_command_nxt = '0;
      end else begin
        integ_nxt            = integ_clamp;
        last_nxt             = cmd_clamp;
        velocity_command_nxt = cmd_clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      last_r  <= '0;
    end else begin
      integ_r <= integ_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    velocity_command_r <= velocity_command_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_velocity_command = velocity_command_r;

  // Checks on the pipeline and the loop state.
  `PVC_ASSERT_NEXT(a_clear_zeroes_state, clk, rst_n, fire3 && clr2_r,
    (integ_r == '0) && (last_r == '0) && (velocity_command_r == '0),
    "clear transfer did not zero the loop state")
  `PVC_ASSERT_NEXT(a_integ_in_limit, clk, rst_n, fire3 && !clr2_r,
    ($signed({integ_r[31], integ_r}) <= $signed({2'b00, $past(ilim_r)})) &&
    ($signed({integ_r[31], integ_r}) >= -$signed({2'b00, $past(ilim_r)})),
    "integral left its limit after a step")
  `PVC_ASSERT_NEXT(a_cmd_in_limit, clk, rst_n, fire3 && !clr2_r,
    ($signed({velocity_command_r[31], velocity_command_r}) <=
      $signed({2'b00, $past(vlim_r)})) &&
    ($signed({velocity_command_r[31], velocity_command_r}) >=
      -$signed({2'b00, $past(vlim_r)})),
    "velocity command outside the velocity limit")
  `PVC_ASSERT_NOW(a_last_matches_out, clk, rst_n, out_valid_r,
    last_r == velocity_command_r,
    "previous command differs from the pending result")
  `PVC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready,
    v1_r && v2_r && out_valid_r && !out_ready,
    "input stalled while the pipeline has room")

endmodule
